// ----- rtl/ps2dec_pkg.sv -----
// Package with the shared types and byte codes of the scan code decoder.
package ps2dec_pkg;

    localparam int unsigned ByteWidth    = 8;
    localparam int unsigned TailWidth    = 3;
    localparam int unsigned SpecialWidth = 2;

    localparam logic [ByteWidth-1:0] CodeRelease   = 8'hF0;
    localparam logic [ByteWidth-1:0] CodeExtended  = 8'hE0;
    localparam logic [ByteWidth-1:0] CodePause     = 8'hE1;
    localparam logic [ByteWidth-1:0] CodePrtMake   = 8'h12;
    localparam logic [ByteWidth-1:0] CodePrtBreak  = 8'h7C;

    localparam logic [TailWidth-1:0] PrtMakeTail   = 3'd2;
    localparam logic [TailWidth-1:0] PrtBreakTail  = 3'd3;
    localparam logic [TailWidth-1:0] PauseTail     = 3'd7;

    typedef enum logic [SpecialWidth-1:0] {
        SPECIAL_NONE  = 2'd0,
        SPECIAL_PRINT = 2'd1,
        SPECIAL_PAUSE = 2'd2
    } t_special;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_REL       = 3'd1,
        PH_EXT       = 3'd2,
        PH_EXT_REL   = 3'd3,
        PH_PRT_MAKE  = 3'd4,
        PH_PRT_BREAK = 3'd5,
        PH_PAUSE     = 3'd6
    } t_phase;

    typedef struct packed {
        logic [ByteWidth-1:0]    key_byte;
        logic                    extended;
        logic                    released;
        logic [SpecialWidth-1:0] special_key;
    } t_key_event;

endpackage

// ----- rtl/ps2dec_if.sv -----
// Interfaces for the scan byte input channel and the key event output channel.
interface ps2dec_byte_if
    import ps2dec_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ByteWidth-1:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink (input valid, input scan_byte, output ready);
endinterface

interface ps2dec_event_if
    import ps2dec_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [ByteWidth-1:0]    key_byte;
    logic                    extended;
    logic                    released;
    logic [SpecialWidth-1:0] special_key;

    modport source (output valid, output key_byte, output extended, output released,
                    output special_key, input ready);
    modport sink (input valid, input key_byte, input extended, input released,
                  input special_key, output ready);
endinterface

// ----- rtl/ps2dec_fsm.sv -----
// Prefix tracking state machine that turns one scan byte into at most one key event.
module ps2dec_fsm
    import ps2dec_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [ByteWidth-1:0] i_byte,
    output logic                 o_emit,
    output t_key_event           o_event
);

    t_phase               r_phase, n_phase;
    logic [TailWidth-1:0] r_tail, n_tail;
    logic [TailWidth-1:0] tail_inc;

    assign tail_inc = r_tail + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tail  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tail  <= n_tail;
        end
    end

    // Next state.
    always_comb begin
        n_phase = PH_IDLE;
        n_tail  = '0;
        unique case (r_phase)
            PH_REL: begin
            end
            PH_EXT: begin
                if (i_byte == CodeRelease) begin
                    n_phase = PH_EXT_REL;
                    n_tail  = r_tail;
                end else if (i_byte == CodePrtMake) begin
                    n_phase = PH_PRT_MAKE;
                end
            end
            PH_EXT_REL: begin
                if (i_byte == CodePrtBreak) begin
                    n_phase = PH_PRT_BREAK;
                end
            end
            PH_PRT_MAKE: begin
                if (tail_inc < PrtMakeTail) begin
                    n_phase = PH_PRT_MAKE;
                    n_tail  = tail_inc;
                end
            end
            PH_PRT_BREAK: begin
                if (tail_inc < PrtBreakTail) begin
                    n_phase = PH_PRT_BREAK;
                    n_tail  = tail_inc;
                end
            end
            PH_PAUSE: begin
                if (tail_inc != PauseTail) begin
                    n_phase = PH_PAUSE;
                    n_tail  = tail_inc;
                end
            end
            default: begin
                n_tail = r_tail;
                if (i_byte == CodeRelease) begin
                    n_phase = PH_REL;
                end else if (i_byte == CodeExtended) begin
                    n_phase = PH_EXT;
                end else if (i_byte == CodePause) begin
                    n_phase = PH_PAUSE;
                    n_tail  = '0;
                end else begin
                    n_tail = '0;
                end
            end
        endcase
    end

    // Event outputs.
    always_comb begin
        o_emit              = 1'b0;
        o_event.key_byte    = i_byte;
        o_event.extended    = 1'b0;
        o_event.released    = 1'b0;
        o_event.special_key = SPECIAL_NONE;
        unique case (r_phase)
            PH_REL: begin
                o_emit           = 1'b1;
                o_event.released = 1'b1;
            end
            PH_EXT: begin
                o_emit           = (i_byte != CodeRelease) && (i_byte != CodePrtMake);
                o_event.extended = 1'b1;
            end
            PH_EXT_REL: begin
                o_emit           = (i_byte != CodePrtBreak);
                o_event.extended = 1'b1;
                o_event.released = 1'b1;
            end
            PH_PRT_MAKE: begin
                o_emit              = (tail_inc >= PrtMakeTail);
                o_event.key_byte    = '0;
                o_event.extended    = 1'b1;
                o_event.special_key = SPECIAL_PRINT;
            end
            PH_PRT_BREAK: begin
                o_emit              = (tail_inc >= PrtBreakTail);
                o_event.key_byte    = '0;
                o_event.extended    = 1'b1;
                o_event.released    = 1'b1;
                o_event.special_key = SPECIAL_PRINT;
            end
            PH_PAUSE: begin
                o_emit              = (tail_inc == PauseTail);
                o_event.key_byte    = '0;
                o_event.extended    = 1'b1;
                o_event.special_key = SPECIAL_PAUSE;
            end
            default: begin
                o_emit = (i_byte != CodeRelease) && (i_byte != CodeExtended)
                         && (i_byte != CodePause);
            end
        endcase
    end

endmodule

// ----- rtl/ps2_set2_scancode_decoder_core.sv -----
// Top level of the scan code set 2 decoder: input register, decoder and event register.
// A key event is captured in the event register when the byte that completes its sequence leaves the input register.
// Throughput: one scan byte per cycle whilst the event sink keeps ready high.
// Both sides are decoupled by an input register and an event register on one shared stall.
// Reset is synchronous and active low; it empties both registers and returns the decoder
// to the idle phase with no prefix seen.
module ps2_set2_scancode_decoder_core
    import ps2dec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ps2dec_byte_if.sink           i_scan,
    ps2dec_event_if.source        o_event
);

    logic                 r_in_valid;
    logic [ByteWidth-1:0] r_in_byte;
    logic                 r_out_valid;
    t_key_event           r_out_event;
    logic                 advance;
    logic                 step;
    logic                 emit;
    t_key_event           next_event;

    assign advance      = !r_out_valid || o_event.ready;
    assign step         = r_in_valid && advance;
    assign i_scan.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_scan.ready) begin
            r_in_valid <= i_scan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.ready && i_scan.valid) begin
            r_in_byte <= i_scan.scan_byte;
        end
    end

    ps2dec_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_emit  (emit),
        .o_event (next_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_event <= next_event;
        end
    end

    assign o_event.valid       = r_out_valid;
    assign o_event.key_byte    = r_out_event.key_byte;
    assign o_event.extended    = r_out_event.extended;
    assign o_event.released    = r_out_event.released;
    assign o_event.special_key = r_out_event.special_key;

endmodule

// ----- rtl/ps2dec_checker.sv -----
// Port level checks of the decoder and the bind that attaches them to the top level.
module ps2dec_checker
    import ps2dec_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [ByteWidth-1:0]    i_key_byte,
    input logic                    i_extended,
    input logic                    i_released,
    input logic [SpecialWidth-1:0] i_special_key
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("event valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_key_byte)
        && $stable(i_special_key) && $stable(i_released))
        else $error("stalled event beat changed");

    a_special_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_special_key != 2'd3)
        else $error("unused special key code");

    a_special_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_special_key != SPECIAL_NONE) |-> i_extended && (i_key_byte == '0))
        else $error("special event without extended flag or with a key byte");

    a_pause_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_special_key == SPECIAL_PAUSE) |-> !i_released)
        else $error("pause event marked as release");

endmodule

bind ps2_set2_scancode_decoder_core ps2dec_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_event.valid),
    .i_out_ready   (o_event.ready),
    .i_key_byte    (o_event.key_byte),
    .i_extended    (o_event.extended),
    .i_released    (o_event.released),
    .i_special_key (o_event.special_key)
);

// ----- tb/tb_ps2_set2_scancode_decoder_core.sv -----
// Self-checking testbench for the scan code set 2 decoder: random and directed byte streams.
module tb_ps2_set2_scancode_decoder_core
    import ps2dec_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned PhaseBytes  = 360;
    localparam int unsigned DrainCycles = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ps2dec_byte_if  scan_if ();
    ps2dec_event_if event_if ();

    ps2_set2_scancode_decoder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_if),
        .o_event (event_if)
    );

    always #1 i_clk = ~i_clk;

    logic [ByteWidth-1:0] bytes_to_send[$];
    t_key_event           expected_events[$];

    t_phase               model_phase = PH_IDLE;
    logic [TailWidth-1:0] model_tail = '0;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_off_left = 0;
    bit          beat_taken = 1'b0;

    int unsigned bytes_sent = 0;
    int unsigned events_seen = 0;
    int unsigned print_events = 0;
    int unsigned pause_events = 0;
    int unsigned release_events = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // Advances the decoder state by one scan byte; returns 1 when a key event completes.
    function automatic bit decode_scan_byte(input logic [ByteWidth-1:0] b,
                                            output t_key_event ev);
        bit hit;
        hit = 1'b0;
        ev  = '0;
        case (model_phase)
            PH_REL: begin
                ev  = '{b, 1'b0, 1'b1, SPECIAL_NONE};
                hit = 1'b1;
            end
            PH_EXT: begin
                if (b == CodeRelease) begin
                    model_phase = PH_EXT_REL;
                end else if (b == CodePrtMake) begin
                    model_phase = PH_PRT_MAKE;
                    model_tail  = '0;
                end else begin
                    ev  = '{b, 1'b1, 1'b0, SPECIAL_NONE};
                    hit = 1'b1;
                end
            end
            PH_EXT_REL: begin
                if (b == CodePrtBreak) begin
                    model_phase = PH_PRT_BREAK;
                    model_tail  = '0;
                end else begin
                    ev  = '{b, 1'b1, 1'b1, SPECIAL_NONE};
                    hit = 1'b1;
                end
            end
            PH_PRT_MAKE: begin
                model_tail = model_tail + 1'b1;
                if (model_tail >= PrtMakeTail) begin
                    ev  = '{8'h00, 1'b1, 1'b0, SPECIAL_PRINT};
                    hit = 1'b1;
                end
            end
            PH_PRT_BREAK: begin
                model_tail = model_tail + 1'b1;
                if (model_tail >= PrtBreakTail) begin
                    ev  = '{8'h00, 1'b1, 1'b1, SPECIAL_PRINT};
                    hit = 1'b1;
                end
            end
            PH_PAUSE: begin
                model_tail = model_tail + 1'b1;
                if (model_tail == PauseTail) begin
                    ev  = '{8'h00, 1'b1, 1'b0, SPECIAL_PAUSE};
                    hit = 1'b1;
                end
            end
            default: begin
                model_phase = PH_IDLE;
                if (b == CodeRelease) begin
                    model_phase = PH_REL;
                end else if (b == CodeExtended) begin
                    model_phase = PH_EXT;
                end else if (b == CodePause) begin
                    model_phase = PH_PAUSE;
                    model_tail  = '0;
                end else begin
                    ev  = '{b, 1'b0, 1'b0, SPECIAL_NONE};
                    hit = 1'b1;
                end
            end
        endcase
        if (hit) begin
            model_phase = PH_IDLE;
            model_tail  = '0;
        end
        return hit;
    endfunction

    function automatic logic [ByteWidth-1:0] tail_byte(input logic [ByteWidth-1:0] usual);
        return ($urandom_range(0, 99) < 20) ? ByteWidth'($urandom_range(0, 255)) : usual;
    endfunction

    // Appends one key sequence, mostly well formed, sometimes with random content or noise.
    task automatic queue_key_sequence();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            bytes_to_send.push_back(ByteWidth'($urandom_range(0, 255)));
        end else if (pick < 45) begin
            bytes_to_send.push_back(CodeRelease);
            bytes_to_send.push_back(ByteWidth'($urandom_range(0, 255)));
        end else if (pick < 58) begin
            bytes_to_send.push_back(CodeExtended);
            bytes_to_send.push_back(ByteWidth'($urandom_range(0, 255)));
        end else if (pick < 70) begin
            bytes_to_send.push_back(CodeExtended);
            bytes_to_send.push_back(CodeRelease);
            bytes_to_send.push_back(ByteWidth'($urandom_range(0, 255)));
        end else if (pick < 78) begin
            bytes_to_send.push_back(CodeExtended);
            bytes_to_send.push_back(CodePrtMake);
            bytes_to_send.push_back(tail_byte(CodeExtended));
            bytes_to_send.push_back(tail_byte(CodePrtBreak));
        end else if (pick < 86) begin
            bytes_to_send.push_back(CodeExtended);
            bytes_to_send.push_back(CodeRelease);
            bytes_to_send.push_back(CodePrtBreak);
            bytes_to_send.push_back(tail_byte(CodeExtended));
            bytes_to_send.push_back(tail_byte(CodeRelease));
            bytes_to_send.push_back(tail_byte(CodePrtMake));
        end else if (pick < 93) begin
            bytes_to_send.push_back(CodePause);
            bytes_to_send.push_back(tail_byte(8'h14));
            bytes_to_send.push_back(tail_byte(8'h77));
            bytes_to_send.push_back(tail_byte(CodePause));
            bytes_to_send.push_back(tail_byte(CodeRelease));
            bytes_to_send.push_back(tail_byte(8'h14));
            bytes_to_send.push_back(tail_byte(CodeRelease));
            bytes_to_send.push_back(tail_byte(8'h77));
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0: bytes_to_send.push_back(CodeRelease);
                    1: bytes_to_send.push_back(CodeExtended);
                    2: bytes_to_send.push_back(CodePause);
                    default: bytes_to_send.push_back(ByteWidth'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    task automatic wait_until_drained();
        while (bytes_to_send.size() != 0 || expected_events.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stl_pct);
        send_idle_pct = idle_pct;
        stall_pct     = stl_pct;
        while (bytes_to_send.size() < PhaseBytes) begin
            queue_key_sequence();
        end
        wait_until_drained();
    endtask

    // Byte source: a beat stays offered until it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && scan_if.valid && scan_if.ready) begin
            t_key_event ev;
            if (decode_scan_byte(scan_if.scan_byte, ev)) begin
                expected_events.push_back(ev);
            end
            void'(bytes_to_send.pop_front());
            bytes_sent++;
            beat_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            scan_if.valid <= 1'b0;
        end else if (!scan_if.valid || beat_taken) begin
            if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                scan_if.valid     <= 1'b1;
                scan_if.scan_byte <= bytes_to_send[0];
            end else begin
                scan_if.valid     <= 1'b0;
                scan_if.scan_byte <= ByteWidth'($urandom_range(0, 255));
            end
        end
        beat_taken = 1'b0;
    end

    // Event sink with random stalls and a long hold-off when the main sequence sets one.
    always @(negedge i_clk) begin
        if (hold_off_left != 0) begin
            hold_off_left--;
            event_if.ready <= 1'b0;
        end else begin
            event_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && event_if.valid && event_if.ready) begin
            t_key_event want;
            events_seen++;
            if (expected_events.size() == 0) begin
                $error("unexpected key event: key_byte=%0h extended=%0b released=%0b special=%0d",
                       event_if.key_byte, event_if.extended, event_if.released,
                       event_if.special_key);
                mismatches++;
            end else begin
                want = expected_events.pop_front();
                if (event_if.key_byte !== want.key_byte) begin
                    $error("key_byte: expected %0h, got %0h", want.key_byte, event_if.key_byte);
                    mismatches++;
                end
                if (event_if.extended !== want.extended) begin
                    $error("extended: expected %0b, got %0b", want.extended, event_if.extended);
                    mismatches++;
                end
                if (event_if.released !== want.released) begin
                    $error("released: expected %0b, got %0b", want.released, event_if.released);
                    mismatches++;
                end
                if (event_if.special_key !== want.special_key) begin
                    $error("special_key: expected %0d, got %0d",
                           want.special_key, event_if.special_key);
                    mismatches++;
                end
                if (want.special_key == SPECIAL_PRINT) print_events++;
                if (want.special_key == SPECIAL_PAUSE) pause_events++;
                if (want.released) release_events++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Timeout after %0d cycles with %0d bytes and %0d events outstanding.",
                     cycle_count, bytes_to_send.size(), expected_events.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        scan_if.valid     = 1'b0;
        scan_if.scan_byte = '0;
        event_if.ready    = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Field extremes, every prefix path and the three special sequences.
        bytes_to_send = '{8'h00, 8'hFF,
                          CodeRelease, CodeRelease,
                          CodeExtended, CodePause,
                          CodeExtended, CodeRelease, 8'h00,
                          CodeExtended, CodePrtMake, CodeExtended, CodePrtBreak,
                          CodeExtended, CodeRelease, CodePrtBreak,
                          CodeExtended, CodeRelease, CodePrtMake,
                          CodePause, 8'h14, 8'h77, CodePause, CodeRelease, 8'h14,
                          CodeRelease, 8'h77};
        wait_until_drained();

        run_random_phase(0, 0);
        run_random_phase(70, 0);
        run_random_phase(0, 70);
        run_random_phase(15, 15);

        // The sink holds off whilst the source keeps offering, so the block back-pressures.
        hold_off_left = 300;
        run_random_phase(0, 0);

        repeat (DrainCycles) @(posedge i_clk);
        if (expected_events.size() != 0) begin
            $error("%0d key events never arrived", expected_events.size());
            mismatches++;
        end

        $display("Sent %0d scan bytes and checked %0d key events (%0d releases).",
                 bytes_sent, events_seen, release_events);
        $display("Special events: %0d print screen, %0d pause; %0d mismatches.",
                 print_events, pause_events, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
